FILE: sv/tcsg_pkg.sv
`default_nettype none

package tcsg_pkg;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_LATCH  = 3'd1,
        OP_WRITE  = 3'd2,
        OP_READ   = 3'd3,
        OP_SAMPLE = 3'd4
    } op_t;

    localparam logic [3:0] REG_NOISE_PER  = 4'd6;
    localparam logic [3:0] REG_MIXER      = 4'd7;
    localparam logic [3:0] REG_AMP_A      = 4'd8;
    localparam logic [3:0] REG_ENV_FINE   = 4'd11;
    localparam logic [3:0] REG_ENV_COARSE = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE  = 4'd13;
    localparam logic [3:0] REG_PORT_A     = 4'd14;
    localparam logic [3:0] REG_PORT_B     = 4'd15;

    localparam int REG_COUNT    = 16;
    localparam int CHAN_COUNT   = 3;
    localparam int MIX_W        = 17;
    localparam int MIX_MAX      = 98304;
    localparam int SAMPLE_W     = 16;
    localparam int Q_W          = 15;
    localparam int SAMPLE_LIMIT = 19661;

    localparam logic [7:0] REG_MASK [REG_COUNT] = '{
        8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'hFF, 8'h0F, 8'h1F, 8'hFF,
        8'h1F, 8'h1F, 8'h1F, 8'hFF, 8'hFF, 8'h0F, 8'hFF, 8'hFF
    };

    localparam logic [15:0] VOL_TABLE [16] = '{
        16'd0,    16'd328,   16'd474,   16'd690,
        16'd1006, 16'd1493,  16'd2114,  16'd3518,
        16'd4148, 16'd6717,  16'd9575,  16'd12217,
        16'd16139, 16'd20818, 16'd26397, 16'd32768
    };

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] channel_on;
        logic [3:0] envelope_level;
        logic       is_sample;
    } beat_info_t;

    function automatic logic [3:0] shape_level(input logic [3:0] shape, input logic [4:0] step);
        logic       dir;
        logic [3:0] lvl;
        dir = shape[2] ^ shape[1];
        if (!step[4]) begin
            lvl = shape[2] ? step[3:0] : ~step[3:0];
        end else if (!shape[3]) begin
            lvl = 4'd0;
        end else if (shape[0]) begin
            lvl = dir ? 4'd15 : 4'd0;
        end else begin
            lvl = dir ? step[3:0] : ~step[3:0];
        end
        return lvl;
    endfunction

endpackage

`default_nettype wire

FILE: sv/three_channel_sound_generator.sv
// Three-channel sound generator with tone, noise and envelope units and a
// DC-removing sample mixer.
// The input channel (in_valid, in_ready, operation, bus_data) carries one bus
// operation per beat: a chip clock tick, an address latch, a data write, a
// data read or a sample request. Every input beat produces exactly one output
// beat (out_valid, out_ready, read_data, sample, channel_on, envelope_level)
// in the same order.
// One beat is accepted every clock cycle while out_ready does not stall the
// pipeline. A result passes through the input register, the state update,
// the DC offset subtraction, the reciprocal multiply that divides by five
// times the window, and the output register.
// The DC filter window holds DC_WINDOW past mix values in a memory with a
// registered read port; entries count as zero until the window has filled.
// Reset clears all state registers, sets the noise shift register to one and the
// envelope to level fifteen in hold mode; no clearing pass is needed.
// When the receiver holds out_ready low, the pipeline fills and then
// in_ready drops; whenever the output register is empty or being taken,
// in_ready is high.
`default_nettype none

module three_channel_sound_generator
    import tcsg_pkg::*;
#(
    parameter int DC_WINDOW = 512
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [2:0]          operation,
    input  wire logic [7:0]          bus_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               read_data,
    output logic signed [SAMPLE_W-1:0] sample,
    output logic [2:0]               channel_on,
    output logic [3:0]               envelope_level
);

    localparam int IDX_W   = (DC_WINDOW > 1) ? $clog2(DC_WINDOW) : 1;
    localparam int SUM_W   = $clog2(MIX_MAX * DC_WINDOW + 1);
    localparam int NUM_W   = SUM_W + 1;
    localparam int DEN     = 5 * DC_WINDOW;
    localparam int DEN2    = 10 * DC_WINDOW;
    localparam int X_W     = $clog2(2 * MIX_MAX * DC_WINDOW + DEN + 1);
    localparam int D_W     = $clog2(DEN2);
    localparam int SHIFT   = X_W + D_W;
    localparam int RECIP_W = X_W + 1;
    localparam int PROD_W  = X_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / 64'(DEN2)) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DC_WINDOW - 1);

    logic       v0_reg;
    logic [2:0] op_reg;
    logic [7:0] data_reg;

    logic             v1_reg;
    beat_info_t       s1_info_reg;
    logic [MIX_W-1:0] s1_mix_reg;
    logic [SUM_W-1:0] s1_sum_reg;

    logic           v2_reg;
    beat_info_t     s2_info_reg;
    logic           s2_neg_reg;
    logic [X_W-1:0] s2_x_reg;

    logic           v3_reg;
    beat_info_t     s3_info_reg;
    logic           s3_neg_reg;
    logic [Q_W-1:0] s3_q_reg;

    logic                vout_reg;
    beat_info_t          out_info_reg;
    logic [SAMPLE_W-1:0] sample_reg;

    logic take0, take1, take2, take3;
    logic free1, free2, free3, free_out;

    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  rf_reg [REG_COUNT];
    logic [7:0]  rf_next [REG_COUNT];
    logic [3:0]  prescale_reg, prescale_next, prescale_inc;
    logic [11:0] tone_count_reg [CHAN_COUNT];
    logic [11:0] tone_count_next [CHAN_COUNT];
    logic [11:0] tone_inc [CHAN_COUNT];
    logic [11:0] tone_per [CHAN_COUNT];
    logic [2:0]  tone_bit_reg, tone_bit_next;
    logic [4:0]  noise_count_reg, noise_count_next, noise_inc, noise_per;
    logic        noise_bit_reg, noise_bit_next;
    logic [16:0] lfsr_reg, lfsr_next;
    logic [15:0] env_count_reg, env_count_next, env_inc, env_per;
    logic [4:0]  env_step_reg, env_step_next, env_step_v;
    logic        env_hold_mode_reg, env_hold_mode_next;
    logic        env_holding_reg, env_holding_next;
    logic [3:0]  env_level_reg, env_level_next;

    logic [MIX_W-1:0] dc_ring [DC_WINDOW];
    logic [MIX_W-1:0] ring_q_reg;
    logic [MIX_W-1:0] ring_old;
    logic [SUM_W-1:0] dc_sum_reg, dc_sum_next;
    logic [IDX_W-1:0] dc_index_reg, dc_index_next;
    logic             dc_filled_reg, dc_filled_next;

    logic [7:0]       rd_value;
    logic             is_sample;
    logic [2:0]       on_next;
    logic [15:0]      vol_sel [CHAN_COUNT];
    logic [MIX_W-1:0] mix;
    beat_info_t       exec_info;

    logic [NUM_W-1:0]  mix_scaled;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  num_abs;
    logic [X_W-1:0]    x_next;
    logic [PROD_W-1:0] q_prod;
    logic [PROD_W-1:0] q_shift;
    logic [SAMPLE_W-1:0] q_ext;

    assign free_out = !vout_reg || out_ready;
    assign take3    = v3_reg && free_out;
    assign free3    = !v3_reg || take3;
    assign take2    = v2_reg && free3;
    assign free2    = !v2_reg || take2;
    assign take1    = v1_reg && free2;
    assign free1    = !v1_reg || take1;
    assign take0    = v0_reg && free1;
    assign in_ready = !v0_reg || take0;

    always_comb
    begin
        addr_next          = addr_reg;
        rf_next            = rf_reg;
        prescale_next      = prescale_reg;
        tone_count_next    = tone_count_reg;
        tone_bit_next      = tone_bit_reg;
        noise_count_next   = noise_count_reg;
        noise_bit_next     = noise_bit_reg;
        lfsr_next          = lfsr_reg;
        env_count_next     = env_count_reg;
        env_step_next      = env_step_reg;
        env_step_v         = env_step_reg;
        env_hold_mode_next = env_hold_mode_reg;
        env_holding_next   = env_holding_reg;
        env_level_next     = env_level_reg;
        rd_value           = 8'd0;
        is_sample          = 1'b0;

        prescale_inc = prescale_reg + 4'd1;
        for (int i = 0; i < CHAN_COUNT; i++) begin
            tone_per[i] = {rf_reg[2 * i + 1][3:0], rf_reg[2 * i]};
            if (tone_per[i] == 12'd0) begin
                tone_per[i] = 12'd1;
            end
            tone_inc[i] = tone_count_reg[i] + 12'd1;
        end
        noise_per = rf_reg[REG_NOISE_PER][4:0];
        if (noise_per == 5'd0) begin
            noise_per = 5'd1;
        end
        noise_inc = noise_count_reg + 5'd1;
        env_per = {rf_reg[REG_ENV_COARSE], rf_reg[REG_ENV_FINE]};
        if (env_per == 16'd0) begin
            env_per = 16'd1;
        end
        env_inc = env_count_reg + 16'd1;

        if (take0) begin
            unique case (op_reg)
                OP_TICK:
                begin
                    prescale_next = prescale_inc;
                    if (prescale_inc[2:0] == 3'd0) begin
                        for (int i = 0; i < CHAN_COUNT; i++) begin
                            if (tone_inc[i] >= tone_per[i]) begin
                                tone_count_next[i] = 12'd0;
                                tone_bit_next[i]   = ~tone_bit_reg[i];
                            end else begin
                                tone_count_next[i] = tone_inc[i];
                            end
                        end
                        if (noise_inc >= noise_per) begin
                            noise_count_next = 5'd0;
                            noise_bit_next   = ~noise_bit_reg;
                            if (!noise_bit_reg) begin
                                lfsr_next = {lfsr_reg[0] ^ lfsr_reg[3], lfsr_reg[16:1]};
                            end
                        end else begin
                            noise_count_next = noise_inc;
                        end
                    end
                    if (prescale_inc == 4'd0) begin
                        if (env_inc >= env_per) begin
                            env_count_next = 16'd0;
                            if (!env_holding_reg) begin
                                env_step_v    = env_step_reg + 5'd1;
                                env_step_next = env_step_v;
                                if (env_hold_mode_reg && env_step_v == 5'd31) begin
                                    env_holding_next = 1'b1;
                                end
                            end
                            env_level_next = shape_level(rf_reg[REG_ENV_SHAPE][3:0], env_step_v);
                        end else begin
                            env_count_next = env_inc;
                        end
                    end
                end
                OP_LATCH:
                begin
                    addr_next = data_reg;
                end
                OP_WRITE:
                begin
                    if (addr_reg[7:4] == 4'd0) begin
                        rf_next[addr_reg[3:0]] = data_reg & REG_MASK[addr_reg[3:0]];
                        if (addr_reg[3:0] == REG_ENV_SHAPE) begin
                            env_holding_next   = 1'b0;
                            env_step_next      = 5'd0;
                            env_hold_mode_next = !data_reg[3] || data_reg[0];
                            env_level_next     = shape_level(data_reg[3:0], 5'd0);
                        end
                    end
                end
                OP_READ:
                begin
                    if (addr_reg[7:4] == 4'd0) begin
                        if (addr_reg[3:0] == REG_PORT_A && !rf_reg[REG_MIXER][6]) begin
                            rd_value = 8'hFF;
                        end else if (addr_reg[3:0] == REG_PORT_B && !rf_reg[REG_MIXER][7]) begin
                            rd_value = 8'hFF;
                        end else begin
                            rd_value = rf_reg[addr_reg[3:0]];
                        end
                    end
                end
                OP_SAMPLE:
                begin
                    is_sample = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        for (int i = 0; i < CHAN_COUNT; i++) begin
            on_next[i] = (tone_bit_next[i] | rf_next[REG_MIXER][i])
                       & (lfsr_next[0] | rf_next[REG_MIXER][3 + i]);
            vol_sel[i] = rf_next[REG_AMP_A + 4'(i)][4] ? VOL_TABLE[env_level_next]
                                                       : VOL_TABLE[rf_next[REG_AMP_A + 4'(i)][3:0]];
        end
        mix = (on_next[0] ? MIX_W'(vol_sel[0]) : '0)
            + (on_next[1] ? MIX_W'(vol_sel[1]) : '0)
            + (on_next[2] ? MIX_W'(vol_sel[2]) : '0);

        ring_old       = dc_filled_reg ? ring_q_reg : '0;
        dc_sum_next    = dc_sum_reg;
        dc_index_next  = dc_index_reg;
        dc_filled_next = dc_filled_reg;
        if (is_sample) begin
            dc_sum_next = dc_sum_reg - SUM_W'(ring_old) + SUM_W'(mix);
            if (dc_index_reg == IDX_LAST) begin
                dc_index_next  = '0;
                dc_filled_next = 1'b1;
            end else begin
                dc_index_next = dc_index_reg + IDX_W'(1);
            end
        end

        exec_info.read_data      = rd_value;
        exec_info.channel_on     = on_next;
        exec_info.envelope_level = env_level_next;
        exec_info.is_sample      = is_sample;
    end

    assign mix_scaled = NUM_W'(s1_mix_reg) * NUM_W'(DC_WINDOW);
    assign num        = mix_scaled - NUM_W'(s1_sum_reg);
    assign num_abs    = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
    assign x_next     = X_W'({num_abs[SUM_W-1:0], 1'b0}) + X_W'(DEN);
    assign q_prod     = PROD_W'(s2_x_reg) * PROD_W'(RECIP);
    assign q_shift    = q_prod >> SHIFT;
    assign q_ext      = SAMPLE_W'(s3_q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v0_reg            <= 1'b0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
            vout_reg          <= 1'b0;
            addr_reg          <= 8'd0;
            rf_reg            <= '{default: 8'd0};
            prescale_reg      <= 4'd0;
            tone_count_reg    <= '{default: 12'd0};
            tone_bit_reg      <= 3'd0;
            noise_count_reg   <= 5'd0;
            noise_bit_reg     <= 1'b0;
            lfsr_reg          <= 17'd1;
            env_count_reg     <= 16'd0;
            env_step_reg      <= 5'd0;
            env_hold_mode_reg <= 1'b1;
            env_holding_reg   <= 1'b0;
            env_level_reg     <= 4'd15;
            dc_sum_reg        <= '0;
            dc_index_reg      <= '0;
            dc_filled_reg     <= 1'b0;
        end else begin
            if (in_ready) begin
                v0_reg <= in_valid;
            end
            if (free1) begin
                v1_reg <= take0;
            end
            if (free2) begin
                v2_reg <= take1;
            end
            if (free3) begin
                v3_reg <= take2;
            end
            if (free_out) begin
                vout_reg <= take3;
            end
            addr_reg          <= addr_next;
            rf_reg            <= rf_next;
            prescale_reg      <= prescale_next;
            tone_count_reg    <= tone_count_next;
            tone_bit_reg      <= tone_bit_next;
            noise_count_reg   <= noise_count_next;
            noise_bit_reg     <= noise_bit_next;
            lfsr_reg          <= lfsr_next;
            env_count_reg     <= env_count_next;
            env_step_reg      <= env_step_next;
            env_hold_mode_reg <= env_hold_mode_next;
            env_holding_reg   <= env_holding_next;
            env_level_reg     <= env_level_next;
            dc_sum_reg        <= dc_sum_next;
            dc_index_reg      <= dc_index_next;
            dc_filled_reg     <= dc_filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            op_reg   <= operation;
            data_reg <= bus_data;
        end
        if (take0) begin
            s1_info_reg <= exec_info;
            s1_mix_reg  <= mix;
            s1_sum_reg  <= dc_sum_next;
        end
        if (take1) begin
            s2_info_reg <= s1_info_reg;
            s2_neg_reg  <= num[NUM_W-1];
            s2_x_reg    <= x_next;
        end
        if (take2) begin
            s3_info_reg <= s2_info_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_q_reg    <= Q_W'(q_shift);
        end
        if (take3) begin
            out_info_reg <= s3_info_reg;
            if (!s3_info_reg.is_sample) begin
                sample_reg <= '0;
            end else if (s3_neg_reg) begin
                sample_reg <= ~q_ext + SAMPLE_W'(1);
            end else begin
                sample_reg <= q_ext;
            end
        end
    end

    // The read port follows the index the next sample will use.
    always_ff @(posedge clk)
    begin
        if (take0 && is_sample) begin
            dc_ring[dc_index_reg] <= mix;
        end
        ring_q_reg <= dc_ring[dc_index_next];
    end

    assign out_valid      = vout_reg;
    assign read_data      = out_info_reg.read_data;
    assign sample         = $signed(sample_reg);
    assign channel_on     = out_info_reg.channel_on;
    assign envelope_level = out_info_reg.envelope_level;

endmodule

`default_nettype wire

FILE: sv/tcsg_checker.sv
`default_nettype none

module tcsg_checker
    import tcsg_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic [2:0]            operation,
    input wire logic [7:0]            bus_data,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [7:0]            read_data,
    input wire logic signed [SAMPLE_W-1:0] sample,
    input wire logic [2:0]            channel_on,
    input wire logic [3:0]            envelope_level
);

    // A waiting input beat keeps its whole payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(bus_data))
        else $error("input beat changed while waiting");

    // A stalled output beat keeps its whole payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sample) && $stable(read_data)
            && $stable(channel_on) && $stable(envelope_level))
        else $error("output beat changed while stalled");

    // An empty or draining output register never blocks the input side.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled while output side is free");

    // Only one of a read value and a sample can come from a single beat.
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> read_data == 8'd0 || sample == '0)
        else $error("read value and sample in the same beat");

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample <= SAMPLE_W'(SAMPLE_LIMIT) && sample >= -SAMPLE_W'(SAMPLE_LIMIT))
        else $error("sample outside the mixer range");

endmodule

bind three_channel_sound_generator tcsg_checker u_tcsg_checker (.*);

`default_nettype wire

FILE: tb/tb_three_channel_sound_generator.sv
`timescale 1ns / 1ps

module tb_three_channel_sound_generator;
    import tcsg_pkg::*;

    localparam int DC_WIN = 512;
    localparam int CYCLE_LIMIT = 500000;
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST = 3'd7;
    localparam logic [7:0] ADDR_OUT_OF_RANGE = 8'hFF;

    typedef struct packed {
        logic [7:0]        rd;
        logic signed [15:0] smp;
        logic [2:0]        on;
        logic [3:0]        env;
    } psg_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] operation = 3'd0;
    logic [7:0] bus_data = 8'd0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [7:0] read_data;
    logic signed [SAMPLE_W-1:0] sample;
    logic [2:0] channel_on;
    logic [3:0] envelope_level;

    three_channel_sound_generator #(
        .DC_WINDOW(DC_WIN)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .bus_data(bus_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_data(read_data),
        .sample(sample),
        .channel_on(channel_on),
        .envelope_level(envelope_level)
    );

    always #1 clk = ~clk;

    // Predicted chip state.
    logic [7:0]  psg_addr;
    logic [7:0]  psg_regs [REG_COUNT];
    logic [3:0]  psg_prescale;
    logic [11:0] psg_tone_cnt [CHAN_COUNT];
    logic        psg_tone_bit [CHAN_COUNT];
    logic [4:0]  psg_noise_cnt;
    logic        psg_noise_bit;
    logic [16:0] psg_lfsr;
    logic [15:0] psg_env_cnt;
    logic [4:0]  psg_env_step;
    logic        psg_hold_mode;
    logic        psg_holding;
    logic [3:0]  psg_env_level;
    logic [16:0] mix_history [DC_WIN];
    logic [25:0] mix_history_sum;
    int          mix_history_pos;

    psg_result_t pending_results [$];
    psg_result_t want;
    int error_count = 0;
    int beat_count = 0;
    int tick_count = 0;
    int sample_count = 0;
    int read_count = 0;
    int cycle_count = 0;
    int ready_hold = 0;
    bit idle_on = 1'b1;

    function automatic logic [3:0] env_shape_level(input logic [3:0] shp, input logic [4:0] stp);
        logic dir;
        dir = shp[2] ^ shp[1];
        if (!stp[4])
            return shp[2] ? stp[3:0] : 4'd15 - stp[3:0];
        if (!shp[3])
            return 4'd0;
        if (shp[0])
            return dir ? 4'd15 : 4'd0;
        return dir ? stp[3:0] : 4'd15 - stp[3:0];
    endfunction

    function automatic logic [2:0] psg_gates();
        logic [2:0] on;
        on = 3'd0;
        for (int i = 0; i < CHAN_COUNT; i++) begin
            if ((psg_tone_bit[i] | psg_regs[REG_MIXER][i]) &&
                (psg_lfsr[0] | psg_regs[REG_MIXER][3+i]))
                on[i] = 1'b1;
        end
        return on;
    endfunction

    task automatic restart_envelope();
        logic [3:0] shp;
        shp = psg_regs[REG_ENV_SHAPE][3:0];
        psg_holding = 1'b0;
        psg_env_step = 5'd0;
        psg_hold_mode = !shp[3] || shp[0];
        psg_env_level = env_shape_level(shp, 5'd0);
    endtask

    task automatic psg_model_reset();
        psg_addr = 8'd0;
        for (int i = 0; i < REG_COUNT; i++)
            psg_regs[i] = 8'd0;
        psg_prescale = 4'd0;
        for (int i = 0; i < CHAN_COUNT; i++) begin
            psg_tone_cnt[i] = 12'd0;
            psg_tone_bit[i] = 1'b0;
        end
        psg_noise_cnt = 5'd0;
        psg_noise_bit = 1'b0;
        psg_lfsr = 17'd1;
        psg_env_cnt = 16'd0;
        for (int i = 0; i < DC_WIN; i++)
            mix_history[i] = 17'd0;
        mix_history_sum = 26'd0;
        mix_history_pos = 0;
        restart_envelope();
    endtask

    task automatic psg_tick();
        int unsigned period;
        logic fb;
        psg_prescale = psg_prescale + 4'd1;
        if (psg_prescale[2:0] == 3'd0) begin
            for (int i = 0; i < CHAN_COUNT; i++) begin
                period = 32'({psg_regs[2*i+1], psg_regs[2*i]});
                if (period == 0)
                    period = 1;
                psg_tone_cnt[i] = psg_tone_cnt[i] + 12'd1;
                if (int'(psg_tone_cnt[i]) >= period) begin
                    psg_tone_cnt[i] = 12'd0;
                    psg_tone_bit[i] = ~psg_tone_bit[i];
                end
            end
            period = 32'(psg_regs[REG_NOISE_PER] & 8'h1F);
            if (period == 0)
                period = 1;
            psg_noise_cnt = psg_noise_cnt + 5'd1;
            if (int'(psg_noise_cnt) >= period) begin
                psg_noise_cnt = 5'd0;
                psg_noise_bit = ~psg_noise_bit;
                if (psg_noise_bit) begin
                    fb = psg_lfsr[0] ^ psg_lfsr[3];
                    psg_lfsr = {fb, psg_lfsr[16:1]};
                end
            end
        end
        if (psg_prescale == 4'd0) begin
            period = 32'({psg_regs[REG_ENV_COARSE], psg_regs[REG_ENV_FINE]});
            if (period == 0)
                period = 1;
            psg_env_cnt = psg_env_cnt + 16'd1;
            if (int'(psg_env_cnt) >= period) begin
                psg_env_cnt = 16'd0;
                if (!psg_holding) begin
                    psg_env_step = psg_env_step + 5'd1;
                    if (psg_hold_mode && psg_env_step == 5'd31)
                        psg_holding = 1'b1;
                end
                psg_env_level = env_shape_level(psg_regs[REG_ENV_SHAPE][3:0], psg_env_step);
            end
        end
    endtask

    task automatic psg_mix_sample(output logic [15:0] smp);
        logic [2:0] on;
        logic [7:0] amp;
        int unsigned mix;
        longint num;
        longint mag;
        longint quo;
        longint den;
        on = psg_gates();
        mix = 0;
        for (int i = 0; i < CHAN_COUNT; i++) begin
            if (on[i]) begin
                amp = psg_regs[REG_AMP_A + i];
                mix += 32'(amp[4] ? VOL_TABLE[psg_env_level] : VOL_TABLE[amp[3:0]]);
            end
        end
        mix_history_sum = 26'(32'(mix_history_sum) - 32'(mix_history[mix_history_pos]) + mix);
        mix_history[mix_history_pos] = 17'(mix);
        mix_history_pos = (mix_history_pos + 1 >= DC_WIN) ? 0 : mix_history_pos + 1;
        num = longint'(mix) * DC_WIN - longint'(mix_history_sum);
        den = longint'(5 * DC_WIN);
        mag = (num < 0) ? -num : num;
        quo = (mag * 2 + den) / (2 * den);
        if (num < 0)
            quo = -quo;
        smp = quo[15:0];
    endtask

    task automatic advance_psg(input logic [2:0] op, input logic [7:0] d,
                               output psg_result_t r);
        logic [3:0] a;
        r.rd = 8'd0;
        r.smp = 16'sd0;
        a = psg_addr[3:0];
        case (op)
            OP_TICK: psg_tick();
            OP_LATCH: psg_addr = d;
            OP_WRITE: begin
                if (psg_addr < REG_COUNT) begin
                    psg_regs[a] = d & REG_MASK[a];
                    if (a == REG_ENV_SHAPE)
                        restart_envelope();
                end
            end
            OP_READ: begin
                if (psg_addr < REG_COUNT) begin
                    if (a == REG_PORT_A && !psg_regs[REG_MIXER][6])
                        r.rd = 8'hFF;
                    else if (a == REG_PORT_B && !psg_regs[REG_MIXER][7])
                        r.rd = 8'hFF;
                    else
                        r.rd = psg_regs[a];
                end
            end
            OP_SAMPLE: psg_mix_sample(r.smp);
            default: ;
        endcase
        r.on = psg_gates();
        r.env = psg_env_level;
    endtask

    task automatic send_beat(input logic [2:0] op, input logic [7:0] d);
        int gap;
        psg_result_t r;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        bus_data <= d;
        do @(posedge clk); while (!in_ready);
        advance_psg(op, d, r);
        pending_results.push_back(r);
        beat_count++;
        if (op == OP_TICK)
            tick_count++;
        if (op == OP_SAMPLE)
            sample_count++;
        if (op == OP_READ)
            read_count++;
    endtask

    task automatic write_reg(input logic [3:0] a, input logic [7:0] v);
        send_beat(OP_LATCH, {4'd0, a});
        send_beat(OP_WRITE, v);
    endtask

    task automatic read_reg(input logic [3:0] a);
        send_beat(OP_LATCH, {4'd0, a});
        send_beat(OP_READ, 8'($urandom));
    endtask

    task automatic test_reset_state();
        send_beat(OP_TICK, 8'hFF);
        read_reg(REG_PORT_A);
        send_beat(OP_SAMPLE, 8'h00);
    endtask

    task automatic test_register_masks();
        write_reg(REG_ENV_SHAPE, 8'hFF);
        send_beat(OP_READ, 8'h00);
        send_beat(OP_LATCH, ADDR_OUT_OF_RANGE);
        send_beat(OP_WRITE, 8'h00);
        send_beat(OP_READ, 8'hFF);
    endtask

    task automatic test_port_direction();
        write_reg(REG_MIXER, 8'hC0);
        write_reg(REG_PORT_B, 8'hFF);
        send_beat(OP_READ, 8'h00);
    endtask

    task automatic test_spare_codes();
        send_beat(OP_SPARE_FIRST, 8'hFF);
        send_beat(OP_SPARE_LAST, 8'h00);
    endtask

    task automatic test_mix_extremes();
        write_reg(REG_MIXER, 8'hFF);
        write_reg(REG_AMP_A, 8'h1F);
        write_reg(REG_AMP_A + 4'd1, 8'h0F);
        send_beat(OP_SAMPLE, 8'h00);
        send_beat(OP_SAMPLE, 8'hFF);
    endtask

    // Register programming followed by bursts of ticks, samples and reads.
    task automatic test_random_programs(input int target);
        int n_regs;
        int kind;
        int len;
        int pick;
        logic [3:0] a;
        logic [7:0] v;
        while (beat_count < target) begin
            idle_on = ($urandom_range(0, 3) != 0);
            n_regs = $urandom_range(0, 4);
            repeat (n_regs) begin
                a = 4'($urandom_range(0, REG_COUNT - 1));
                if (a == REG_ENV_SHAPE && $urandom_range(0, 3) != 0)
                    a = REG_MIXER;
                v = 8'($urandom);
                if (a < REG_NOISE_PER) begin
                    if (a[0] && $urandom_range(0, 3) != 0)
                        v = 8'd0;
                    else if (!a[0] && $urandom_range(0, 1) != 0)
                        v = 8'($urandom_range(0, 4));
                end else if (a == REG_ENV_FINE && $urandom_range(0, 3) != 0) begin
                    v = 8'($urandom_range(0, 2));
                end else if (a == REG_ENV_COARSE && $urandom_range(0, 7) != 0) begin
                    v = 8'd0;
                end
                write_reg(a, v);
            end
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                len = $urandom_range(10, 40);
                repeat (len) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        send_beat(OP_TICK, 8'($urandom));
                    else if (pick < 9)
                        send_beat(OP_SAMPLE, 8'($urandom));
                    else
                        read_reg(4'($urandom_range(0, REG_COUNT - 1)));
                end
            end else if (kind < 6) begin
                len = $urandom_range(64, 160);
                repeat (len) send_beat(OP_TICK, 8'($urandom));
            end else begin
                len = $urandom_range(40, 100);
                repeat (len) begin
                    if ($urandom_range(0, 1) != 0)
                        send_beat(OP_TICK, 8'($urandom));
                    send_beat(OP_SAMPLE, 8'($urandom));
                end
            end
        end
    endtask

    task automatic test_random_noise(input int target);
        while (beat_count < target) begin
            if ($urandom_range(0, 15) == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            send_beat(3'($urandom_range(0, 7)), 8'($urandom));
        end
    endtask

    // Receiver: after each taken beat, hold ready low for a random stall, possibly none.
    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            ready_hold = idle_on ? $urandom_range(0, 8) : 0;
            out_ready <= (ready_hold == 0);
        end else if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            out_ready <= (ready_hold == 0);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: output beat with no expected result", $time);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (read_data !== want.rd) begin
                    $display("%0t: read_data expected %0d actual %0d", $time, want.rd, read_data);
                    error_count++;
                end
                if (sample !== want.smp) begin
                    $display("%0t: sample expected %0d actual %0d", $time,
                             $signed(want.smp), sample);
                    error_count++;
                end
                if (channel_on !== want.on) begin
                    $display("%0t: channel_on expected %0d actual %0d", $time,
                             want.on, channel_on);
                    error_count++;
                end
                if (envelope_level !== want.env) begin
                    $display("%0t: envelope_level expected %0d actual %0d", $time,
                             want.env, envelope_level);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        psg_model_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_register_masks();
        test_port_direction();
        test_spare_codes();
        test_mix_extremes();
        test_random_programs(1620);
        test_random_noise(1875);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Run covered %0d beats: %0d ticks, %0d samples, %0d reads,", beat_count,
                 tick_count, sample_count, read_count);
        $display("with register programming, spare codes and random stalls on both sides.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
